// ===== design/qalu_pkg.sv =====
// qalu_pkg: shared types, widths, opcodes and the Hamilton product term table
// for the quaternion ALU. No dependencies.
package qalu_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int LANES  = 4;
	localparam int TERMS  = 4;
	localparam int TK_W   = $clog2(TERMS);
	localparam int PROD_W = 2 * WORD_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int NUM_W  = WORD_W + FRAC_W;
	localparam int DEN_W  = SUM_W - 1 - FRAC_W;
	localparam int ROOT_W = SUM_W / 2;

	// register count from the accepting edge to the result register
	localparam int PIPE_LAT = 5 + ROOT_W + NUM_W;

	typedef logic signed [WORD_W-1:0] sword_t;
	typedef logic signed [PROD_W-1:0] sprod_t;
	typedef logic signed [SUM_W-1:0]  ssum_t;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_SCALE = 4'd3,
		OP_DIV   = 4'd4,
		OP_CONJ  = 4'd5,
		OP_INV   = 4'd6,
		OP_NORM  = 4'd7,
		OP_EQUAL = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_DIVZERO = 2'd1,
		ST_SAT     = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]  func;
		sword_t      a_s;
		sword_t      a_x;
		sword_t      a_y;
		sword_t      a_z;
		sword_t      b_s;
		sword_t      b_x;
		sword_t      b_y;
		sword_t      b_z;
	} in_t;

	typedef struct packed {
		sword_t      r_s;
		sword_t      r_x;
		sword_t      r_y;
		sword_t      r_z;
		logic        is_equal;
		logic [1:0]  status;
	} out_t;

	// per-item sideband carried alongside the root and divider pipelines
	typedef struct packed {
		logic [3:0]                        func;
		logic                              eq;
		logic                              dz;
		logic [LANES-1:0]                  neg;
		logic [LANES-1:0]                  sat;
		logic [LANES-1:0][WORD_W-1:0]      r;
		logic [LANES-1:0][NUM_W-1:0]       num;
		logic [DEN_W-1:0]                  den;
	} sb_t;

	typedef struct packed {
		logic        sat;
		logic [WORD_W-1:0] val;
	} sat_t;

	// Hamilton product: operand indexes and subtract flags per lane and term
	localparam logic [TK_W-1:0] HAM_A [LANES][TERMS] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd3, 2'd1},
		'{2'd0, 2'd3, 2'd1, 2'd2}
	};
	localparam logic [TK_W-1:0] HAM_B [LANES][TERMS] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd2, 2'd1}
	};
	localparam logic [TERMS-1:0] HAM_NEG [LANES] = '{
		4'b1110, 4'b1000, 4'b1000, 4'b1000
	};
	// term that holds a_i * b_s in each lane
	localparam logic [TK_W-1:0] SCALE_K [LANES] = '{2'd0, 2'd1, 2'd1, 2'd1};

	localparam ssum_t SAT_HI = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
	localparam ssum_t SAT_LO = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};

	// clamp a wide signed value to the word range
	function automatic sat_t sat_word(input ssum_t v);
		sat_t res;
		res.sat = 1'b0;
		res.val = v[WORD_W-1:0];
		if (v > SAT_HI) begin
			res.sat = 1'b1;
			res.val = SAT_HI[WORD_W-1:0];
		end else if (v < SAT_LO) begin
			res.sat = 1'b1;
			res.val = SAT_LO[WORD_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== design/qalu_lane.sv =====
// qalu_lane: one product lane, four signed multiplies and a two-level adder
// tree (three register stages). Depends on qalu_pkg.
module qalu_lane (
	input  logic                            clk,
	input  qalu_pkg::sword_t                op_a [qalu_pkg::TERMS],
	input  qalu_pkg::sword_t                op_b [qalu_pkg::TERMS],
	input  logic [qalu_pkg::TERMS-1:0]      neg,
	input  logic [qalu_pkg::TK_W-1:0]       scale_k,
	output qalu_pkg::ssum_t                 sum,
	output qalu_pkg::sprod_t                scale_p
);
	import qalu_pkg::*;

	sprod_t                  prod_s2 [TERMS];
	logic [TERMS-1:0]        neg_s2;
	logic signed [SUM_W-2:0] term [TERMS];
	logic signed [SUM_W-2:0] pair_s3 [2];
	sprod_t                  scale_s3;
	sprod_t                  scale_s4;
	ssum_t                   sum_s4;

	// multipliers
	always_ff @(posedge clk) begin
		for (int k = 0; k < TERMS; k++) begin
			prod_s2[k] <= op_a[k] * op_b[k];
		end
		neg_s2 <= neg;
	end

	// apply term signs
	always_comb begin
		for (int k = 0; k < TERMS; k++) begin
			term[k] = neg_s2[k] ? -((SUM_W-1)'(prod_s2[k])) : (SUM_W-1)'(prod_s2[k]);
		end
	end

	// adder tree
	always_ff @(posedge clk) begin
		pair_s3[0] <= term[0] + term[1];
		pair_s3[1] <= term[2] + term[3];
		scale_s3   <= prod_s2[scale_k];
		sum_s4     <= SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);
		scale_s4   <= scale_s3;
	end

	assign sum     = sum_s4;
	assign scale_p = scale_s4;

endmodule

// ===== design/qalu_sqrt.sv =====
// qalu_sqrt: pipelined integer square root, one root bit per stage.
// Depends on qalu_pkg.
module qalu_sqrt (
	input  logic                           clk,
	input  logic [qalu_pkg::SUM_W-1:0]     val,
	output logic [qalu_pkg::ROOT_W-1:0]    root
);
	import qalu_pkg::*;

	logic [ROOT_W:0]   rem_s  [ROOT_W-1];
	logic [SUM_W-1:0]  rest_s [ROOT_W-1];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		logic [ROOT_W:0]   rem_in;
		logic [SUM_W-1:0]  rest_in;
		logic [ROOT_W-1:0] root_in;
		logic [ROOT_W+2:0] cur;
		logic [ROOT_W+2:0] tst;
		logic [ROOT_W+2:0] diff;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign rest_in = val;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign rest_in = rest_s[j-1];
			assign root_in = root_s[j-1];
		end

		// bring down two bits and try the next root bit
		assign cur  = {rem_in, rest_in[SUM_W-1:SUM_W-2]};
		assign tst  = {1'b0, root_in, 2'b01};
		assign ge   = cur >= tst;
		assign diff = cur - tst;

		always_ff @(posedge clk) begin
			root_s[j] <= {root_in[ROOT_W-2:0], ge};
		end

		if (j < ROOT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j]  <= ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
				rest_s[j] <= {rest_in[SUM_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

// ===== design/qalu_div.sv =====
// qalu_div: pipelined restoring divider, one quotient bit per stage, for
// unsigned magnitudes. Depends on qalu_pkg.
module qalu_div (
	input  logic                          clk,
	input  logic [qalu_pkg::NUM_W-1:0]    num,
	input  logic [qalu_pkg::DEN_W-1:0]    den,
	output logic [qalu_pkg::NUM_W-1:0]    quo
);
	import qalu_pkg::*;

	logic [DEN_W-1:0] rem_s [NUM_W-1];
	logic [DEN_W-1:0] den_s [NUM_W-1];
	logic [NUM_W-1:0] nq_s  [NUM_W];

	for (genvar j = 0; j < NUM_W; j++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [NUM_W-1:0] nq_in;
		logic [DEN_W:0]   cur;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = den;
			assign nq_in  = num;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign nq_in  = nq_s[j-1];
		end

		// shift in the next numerator bit and subtract when it fits
		assign cur  = {rem_in, nq_in[NUM_W-1]};
		assign ge   = cur >= {1'b0, den_in};
		assign diff = cur - {1'b0, den_in};

		always_ff @(posedge clk) begin
			nq_s[j] <= {nq_in[NUM_W-2:0], ge};
		end

		if (j < NUM_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
				den_s[j] <= den_in;
			end
		end
	end

	assign quo = nq_s[NUM_W-1];

endmodule

// ===== design/quaternion_alu.sv =====
// quaternion_alu: top level of the Q16.16 quaternion ALU, four product lanes,
// a root pipeline, four divider lanes and the result merge.
// Depends on qalu_pkg, qalu_lane, qalu_sqrt and qalu_div.
//
// Usage:
//   An item (opcode and two quaternions on operands) is taken at each rising
//   edge where start is high and busy is low. busy stays low: the pipeline
//   takes a new item every cycle, so the throughput is one item per clock.
//   Every item goes through the whole pipeline, whatever the opcode: done is high for
//   one cycle when the item reaches the output register, with the result on
//   result. The pipeline is four stages of input, multiply and adder tree,
//   33 root stages (one root bit each) and 48 divider stages (one quotient
//   bit each), then the output register.
//   Results leave in accept order. The receiver cannot stall; done is a
//   strobe and the result is gone the cycle after.
//   Reset clears all item valid flags, so no done comes out of items that
//   were in flight; there are no configuration registers and no state
//   beyond the pipeline.
module quaternion_alu (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  qalu_pkg::in_t   operands,
	output logic            done,
	output qalu_pkg::out_t  result
);
	import qalu_pkg::*;

	localparam int SQRT_LAT = ROOT_W;
	localparam int DIV_LAT  = NUM_W;

	logic [3:0] func_s1, func_s2, func_s3, func_s4;
	sword_t     a_s1 [LANES];
	sword_t     b_s1 [LANES];
	sword_t     a_s2 [LANES];
	sword_t     b_s2 [LANES];
	sword_t     a_s3 [LANES];
	sword_t     b_s3 [LANES];
	sword_t     a_s4 [LANES];
	sword_t     b_s4 [LANES];
	logic       vld_s1, vld_s2, vld_s3, vld_s4;
	logic       sq_mode;

	ssum_t      lane_sum   [LANES];
	sprod_t     lane_scale [LANES];

	logic [ROOT_W-1:0] root;
	sb_t               sb_in;
	sb_t               sqrt_sb_s [SQRT_LAT];
	sb_t               div_sb_s  [DIV_LAT];
	logic [SQRT_LAT-1:0] sqrt_vld_q;
	logic [DIV_LAT-1:0]  div_vld_q;
	sb_t               sb_mid;
	sb_t               sb_end;
	logic [DEN_W-1:0]  den_use;
	logic [NUM_W-1:0]  quo [LANES];

	out_t              rsp_d;
	out_t              rsp_q;
	logic              done_q;

	assign busy = 1'b0;

	// input register; inverse and normalize square the first operand
	assign sq_mode = (operands.func == OP_INV) || (operands.func == OP_NORM);

	always_ff @(posedge clk) begin
		func_s1 <= operands.func;
		a_s1[0] <= operands.a_s;
		a_s1[1] <= operands.a_x;
		a_s1[2] <= operands.a_y;
		a_s1[3] <= operands.a_z;
		b_s1[0] <= sq_mode ? operands.a_s : operands.b_s;
		b_s1[1] <= sq_mode ? operands.a_x : operands.b_x;
		b_s1[2] <= sq_mode ? operands.a_y : operands.b_y;
		b_s1[3] <= sq_mode ? operands.a_z : operands.b_z;
	end

	// operand sideband alongside the lanes
	always_ff @(posedge clk) begin
		func_s2 <= func_s1;
		func_s3 <= func_s2;
		func_s4 <= func_s3;
		for (int l = 0; l < LANES; l++) begin
			a_s2[l] <= a_s1[l];
			b_s2[l] <= b_s1[l];
			a_s3[l] <= a_s2[l];
			b_s3[l] <= b_s2[l];
			a_s4[l] <= a_s3[l];
			b_s4[l] <= b_s3[l];
		end
	end

	// item valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			sqrt_vld_q <= '0;
			div_vld_q  <= '0;
			done_q     <= 1'b0;
		end else begin
			vld_s1     <= start && !busy;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			sqrt_vld_q <= {sqrt_vld_q[SQRT_LAT-2:0], vld_s4};
			div_vld_q  <= {div_vld_q[DIV_LAT-2:0], sqrt_vld_q[SQRT_LAT-1]};
			done_q     <= div_vld_q[DIV_LAT-1];
		end
	end

	// product lanes
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		sword_t            la [TERMS];
		sword_t            lb [TERMS];
		logic [TERMS-1:0]  lneg;

		for (genvar k = 0; k < TERMS; k++) begin : g_term
			assign la[k] = a_s1[HAM_A[l][k]];
			assign lb[k] = b_s1[HAM_B[l][k]];
		end
		assign lneg = ((func_s1 == OP_INV) || (func_s1 == OP_NORM)) ? '0 : HAM_NEG[l];

		qalu_lane u_lane (
			.clk     (clk),
			.op_a    (la),
			.op_b    (lb),
			.neg     (lneg),
			.scale_k (SCALE_K[l]),
			.sum     (lane_sum[l]),
			.scale_p (lane_scale[l])
		);
	end

	// magnitude from the sum of squares
	qalu_sqrt u_sqrt (
		.clk  (clk),
		.val  ($unsigned(lane_sum[0])),
		.root (root)
	);

	// direct results, divider operands and zero-divisor check
	always_comb begin
		sword_t      av;
		logic [WORD_W-1:0] mag;
		sat_t        sr;
		logic [DEN_W-1:0] bmag;

		sb_in      = '0;
		sb_in.func = func_s4;
		sb_in.eq   = (func_s4 == OP_EQUAL) && (a_s4[0] == b_s4[0]) &&
			(a_s4[1] == b_s4[1]) && (a_s4[2] == b_s4[2]) && (a_s4[3] == b_s4[3]);
		bmag = DEN_W'(b_s4[0][WORD_W-1] ? $unsigned(-b_s4[0]) : $unsigned(b_s4[0]));

		case (func_s4)
			OP_DIV: begin
				sb_in.den = bmag;
				sb_in.dz  = (b_s4[0] == '0);
			end
			OP_INV: begin
				sb_in.den = lane_sum[0][SUM_W-2:FRAC_W];
				sb_in.dz  = (lane_sum[0][SUM_W-2:FRAC_W] == '0);
			end
			OP_NORM: begin
				sb_in.dz  = (lane_sum[0] == '0);
			end
			default: begin
				sb_in.dz  = 1'b0;
			end
		endcase

		for (int l = 0; l < LANES; l++) begin
			av  = a_s4[l];
			mag = av[WORD_W-1] ? WORD_W'(-av) : WORD_W'(av);
			sb_in.num[l] = {mag, {FRAC_W{1'b0}}};
			sr = '0;
			case (func_s4)
				OP_ADD:   sr = sat_word(SUM_W'(av) + SUM_W'(b_s4[l]));
				OP_SUB:   sr = sat_word(SUM_W'(av) - SUM_W'(b_s4[l]));
				OP_MUL:   sr = sat_word(lane_sum[l] >>> FRAC_W);
				OP_SCALE: sr = sat_word(SUM_W'(lane_scale[l] >>> FRAC_W));
				OP_CONJ:  sr = (l == 0) ? sat_word(SUM_W'(av)) : sat_word(-SUM_W'(av));
				OP_DIV:   sb_in.neg[l] = av[WORD_W-1] ^ b_s4[0][WORD_W-1];
				OP_INV: begin
					if (l == 0) begin
						sb_in.neg[l] = av[WORD_W-1];
					end else begin
						sb_in.neg[l] = !av[WORD_W-1] && (av != '0);
					end
				end
				OP_NORM:  sb_in.neg[l] = av[WORD_W-1];
				default:  sr = '0;
			endcase
			sb_in.r[l]   = sr.val;
			sb_in.sat[l] = sr.sat;
		end
	end

	// sideband delay matched to the root pipeline, then to the dividers
	always_ff @(posedge clk) begin
		sqrt_sb_s[0] <= sb_in;
		for (int k = 1; k < SQRT_LAT; k++) begin
			sqrt_sb_s[k] <= sqrt_sb_s[k-1];
		end
		div_sb_s[0] <= sqrt_sb_s[SQRT_LAT-1];
		for (int k = 1; k < DIV_LAT; k++) begin
			div_sb_s[k] <= div_sb_s[k-1];
		end
	end

	assign sb_mid  = sqrt_sb_s[SQRT_LAT-1];
	assign sb_end  = div_sb_s[DIV_LAT-1];
	assign den_use = (sb_mid.func == OP_NORM) ? DEN_W'(root) : sb_mid.den;

	// divider lanes
	for (genvar l = 0; l < LANES; l++) begin : g_div
		qalu_div u_div (
			.clk (clk),
			.num (sb_mid.num[l]),
			.den (den_use),
			.quo (quo[l])
		);
	end

	// merge lane results, sign, saturation and status
	always_comb begin
		logic              div_op;
		logic              sat_any;
		ssum_t             qext;
		sat_t              sr;
		logic [LANES-1:0][WORD_W-1:0] rv;

		div_op  = (sb_end.func == OP_DIV) || (sb_end.func == OP_INV) ||
			(sb_end.func == OP_NORM);
		sat_any = 1'b0;
		rv      = '0;
		for (int l = 0; l < LANES; l++) begin
			qext = {{(SUM_W-NUM_W){1'b0}}, quo[l]};
			sr   = sat_word(sb_end.neg[l] ? -qext : qext);
			if (div_op) begin
				if (!sb_end.dz) begin
					rv[l]   = sr.val;
					sat_any = sat_any | sr.sat;
				end
			end else begin
				rv[l]   = sb_end.r[l];
				sat_any = sat_any | sb_end.sat[l];
			end
		end

		rsp_d.r_s      = rv[0];
		rsp_d.r_x      = rv[1];
		rsp_d.r_y      = rv[2];
		rsp_d.r_z      = rv[3];
		rsp_d.is_equal = sb_end.eq;
		if (div_op && sb_end.dz) begin
			rsp_d.status = ST_DIVZERO;
		end else if (sat_any) begin
			rsp_d.status = ST_SAT;
		end else begin
			rsp_d.status = ST_OK;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign done   = done_q;
	assign result = rsp_q;

	// every accepted item gives a done after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("item accepted without result after pipeline latency");

	// no done without an item accepted at the matching edge
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_LAT))
		else $error("result without an accepted item");

	// division by zero gives an all-zero quaternion
	a_divzero_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_DIVZERO)) |->
		(result.r_s == '0) && (result.r_x == '0) && (result.r_y == '0) &&
		(result.r_z == '0) && !result.is_equal)
		else $error("division by zero result not cleared");

	// equality hit only with an ok status and zero scalar and z parts
	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_equal) |->
		(result.status == ST_OK) && (result.r_s == '0) && (result.r_z == '0))
		else $error("equality result carries data or status");

endmodule

// ===== bench/quaternion_alu_test.sv =====
// quaternion_alu_test: self-checking bench for the Q16.16 quaternion ALU.
// Depends on qalu_pkg and quaternion_alu; drives random and corner items.
module quaternion_alu_test;
	timeunit 1ns;
	timeprecision 1ps;
	import qalu_pkg::*;

	localparam int WATCHDOG = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t operands = '0;
	logic done;
	out_t result;

	in_t pending_items[$];
	out_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	int gap = 0;
	bit stim_done = 1'b0;

	quaternion_alu i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	// clock
	always #5 clk = ~clk;

	// floor shift of a wide signed value
	function automatic logic signed [127:0] floor_frac(input logic signed [127:0] v);
		return v >>> FRAC_W;
	endfunction

	// clamp to the word range and note saturation
	function automatic logic signed [127:0] clamp_word(input logic signed [127:0] v,
			inout bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 128'sd2147483647;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return -128'sd2147483648;
		end
		return v;
	endfunction

	// signed quotient (num << frac) / den, truncated toward zero
	function automatic logic signed [127:0] fixed_quot(input logic signed [127:0] num,
			input logic signed [127:0] den);
		logic signed [127:0] n;
		n = num <<< FRAC_W;
		return n / den;
	endfunction

	// floor integer square root of a wide unsigned value
	function automatic logic [127:0] floor_root(input logic [127:0] v);
		logic [127:0] root, rem, trial;
		root = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// expected quaternion result of one item
	function automatic out_t quat_result(input in_t it);
		logic signed [127:0] a[4], b[4], r[4], acc, sumsq, den, c;
		out_t o;
		bit sat;
		bit dz;
		sat = 1'b0;
		dz = 1'b0;
		o = '0;
		a[0] = 128'(it.a_s); a[1] = 128'(it.a_x); a[2] = 128'(it.a_y); a[3] = 128'(it.a_z);
		b[0] = 128'(it.b_s); b[1] = 128'(it.b_x); b[2] = 128'(it.b_y); b[3] = 128'(it.b_z);
		for (int i = 0; i < 4; i++) r[i] = '0;
		sumsq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
		case (it.func)
			OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp_word(a[i] + b[i], sat);
			OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp_word(a[i] - b[i], sat);
			OP_MUL: begin
				acc = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
				r[0] = clamp_word(floor_frac(acc), sat);
				acc = a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2];
				r[1] = clamp_word(floor_frac(acc), sat);
				acc = a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3];
				r[2] = clamp_word(floor_frac(acc), sat);
				acc = a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1];
				r[3] = clamp_word(floor_frac(acc), sat);
			end
			OP_SCALE: for (int i = 0; i < 4; i++)
				r[i] = clamp_word(floor_frac(a[i] * b[0]), sat);
			OP_DIV: begin
				if (b[0] == 0) dz = 1'b1;
				else for (int i = 0; i < 4; i++) r[i] = clamp_word(fixed_quot(a[i], b[0]), sat);
			end
			OP_CONJ: begin
				r[0] = clamp_word(a[0], sat);
				for (int i = 1; i < 4; i++) r[i] = clamp_word(-a[i], sat);
			end
			OP_INV: begin
				den = floor_frac(sumsq);
				if (den == 0) dz = 1'b1;
				else for (int i = 0; i < 4; i++) begin
					c = (i == 0) ? a[0] : -a[i];
					r[i] = clamp_word(fixed_quot(c, den), sat);
				end
			end
			OP_NORM: begin
				den = floor_root(sumsq);
				if (den == 0) dz = 1'b1;
				else for (int i = 0; i < 4; i++) r[i] = clamp_word(fixed_quot(a[i], den), sat);
			end
			OP_EQUAL: o.is_equal = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]
				&& a[3] == b[3]);
			default: ;
		endcase
		if (!(dz || it.func inside {[4'd9:4'd15]})) begin
			o.r_s = r[0][31:0]; o.r_x = r[1][31:0]; o.r_y = r[2][31:0]; o.r_z = r[3][31:0];
		end
		o.status = dz ? ST_DIVZERO : (sat ? ST_SAT : ST_OK);
		return o;
	endfunction

	// random operand word, biased toward corners and small values
	function automatic sword_t rand_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sh0;
			3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			4: return 32'sh10000;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_t rand_item();
		in_t it;
		it.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(0, 8));
		it.a_s = rand_word(); it.a_x = rand_word(); it.a_y = rand_word(); it.a_z = rand_word();
		if ($urandom_range(0, 5) == 0) begin
			it.b_s = it.a_s; it.b_x = it.a_x; it.b_y = it.a_y; it.b_z = it.a_z;
		end else begin
			it.b_s = rand_word(); it.b_x = rand_word(); it.b_y = rand_word();
			it.b_z = rand_word();
		end
		if ($urandom_range(0, 9) == 0 && it.func == OP_EQUAL) it.b_z = it.b_z ^ 32'h1;
		return it;
	endfunction

	function automatic in_t make_item(input op_t f, input sword_t av, input sword_t bv);
		in_t it;
		it.func = f;
		it.a_s = av; it.a_x = av; it.a_y = av; it.a_z = av;
		it.b_s = bv; it.b_x = bv; it.b_y = bv; it.b_z = bv;
		return it;
	endfunction

	// stimulus: directed corners then random items
	initial begin
		in_t it;
		for (int f = 0; f <= 8; f++)
			pending_items.push_back(make_item(op_t'(f), 32'sh7fffffff, 32'sh80000000));
		pending_items.push_back(make_item(OP_DIV, 32'sh10000, 32'sh0));
		pending_items.push_back(make_item(OP_INV, 32'sh0, 32'sh0));
		pending_items.push_back(make_item(OP_NORM, 32'sh0, 32'sh0));
		pending_items.push_back(make_item(OP_INV, 32'sh1, 32'sh0));
		pending_items.push_back(make_item(OP_NORM, 32'sh10000, 32'sh0));
		pending_items.push_back(make_item(OP_CONJ, 32'sh80000000, 32'sh0));
		pending_items.push_back(make_item(OP_EQUAL, 32'sh1234, 32'sh1234));
		pending_items.push_back(make_item(OP_MUL, 32'sh10000, 32'sh20000));
		pending_items.push_back(make_item(OP_DIV, -32'sh30000, 32'sh20000));
		pending_items.push_back(make_item(OP_SCALE, -32'sh1, 32'sh1));
		it = make_item(OP_ADD, 32'sh0, 32'sh0);
		it.func = 4'd15;
		pending_items.push_back(it);
		it.func = 4'd9;
		pending_items.push_back(it);
		for (int n = 0; n < 1100; n++) pending_items.push_back(rand_item());
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: one item per handshake, random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				void'(pending_items.pop_front());
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
			end
			if (gap > 0) begin
				gap = gap - 1;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				start <= 1'b1;
				operands <= pending_items[0];
			end else begin
				start <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// monitor: predict on accept, compare on done
	always @(posedge clk) begin
		out_t exp_r;
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (start && !busy) begin
				expected_results.push_back(quat_result(operands));
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no item pending");
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (result.r_s !== exp_r.r_s) begin
						$error("r_s expected %h got %h", exp_r.r_s, result.r_s); errors++;
					end
					if (result.r_x !== exp_r.r_x) begin
						$error("r_x expected %h got %h", exp_r.r_x, result.r_x); errors++;
					end
					if (result.r_y !== exp_r.r_y) begin
						$error("r_y expected %h got %h", exp_r.r_y, result.r_y); errors++;
					end
					if (result.r_z !== exp_r.r_z) begin
						$error("r_z expected %h got %h", exp_r.r_z, result.r_z); errors++;
					end
					if (result.is_equal !== exp_r.is_equal) begin
						$error("is_equal expected %b got %b", exp_r.is_equal, result.is_equal);
						errors++;
					end
					if (result.status !== exp_r.status) begin
						$error("status expected %0d got %0d", exp_r.status, result.status);
						errors++;
					end
				end
			end
		end
	end

	// end of run and watchdog
	initial begin
		wait (stim_done && expected_results.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
design/qalu_pkg.sv
design/qalu_lane.sv
design/qalu_sqrt.sv
design/qalu_div.sv
design/quaternion_alu.sv
bench/quaternion_alu_test.sv
